FILE: sv/pfd_pkg.sv
package pfd_pkg;

  // field widths, Q16.16 data
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DT_W    = 24;
  localparam int LIM_W   = 31;
  localparam int ALPHA_W = 17;
  localparam int IDX_W   = 3;

  // shared multiplier: magnitude operands, product of both widths
  localparam int MUL_A_W = 2 * DATA_W - 1;
  localparam int MUL_B_W = DATA_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // divider: error difference magnitude scaled by 2^16 over the time step
  localparam int DIV_NUM_W = DATA_W + FRAC_W;
  localparam int DIV_DEN_W = DT_W;

  // integral increment, integral sum before clamp
  localparam int INC_W = MUL_A_W + DT_W - DATA_W;
  localparam int SUM_W = INC_W + 2;

  // filter product magnitude, signed gain product, drive sum
  localparam int FILT_P_W = DATA_W + 1 + ALPHA_W;
  localparam int KPROD_W  = 2 * DATA_W;
  localparam int DRV_W    = KPROD_W - FRAC_W + 2;

  // default digit widths of the serial units
  localparam int MUL_DIGIT_DEF = 4;
  localparam int DIV_STEP_DEF  = 2;

  // register reset values
  localparam logic [DATA_W-1:0]  PROP_GAIN_RST   = 32'd65536;
  localparam logic [DATA_W-1:0]  DERIV_GAIN_RST  = 32'd6554;
  localparam logic [DATA_W-1:0]  INTEG_GAIN_RST  = 32'd655;
  localparam logic [LIM_W-1:0]   INTEG_LIMIT_RST = 31'd655360;
  localparam logic [ALPHA_W-1:0] DERIV_ALPHA_RST = 17'd39322;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;
  localparam logic [DATA_W-1:0]  DATA_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]  DATA_MIN  = 32'h8000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DERIV_ALPHA = 3'd4
  } pfd_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_GE,
    ST_GEDT,
    ST_CLAMP,
    ST_KPE,
    ST_WDIV,
    ST_FSTART,
    ST_FILT,
    ST_KSTART,
    ST_KDF,
    ST_CLEAR,
    ST_DONE
  } pfd_state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } pfd_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] product;
  } pfd_mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } pfd_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } pfd_div_rsp_t;

endpackage

FILE: sv/pfd_serial_mul.sv
module pfd_serial_mul #(
  parameter int DIGIT_W = pfd_pkg::MUL_DIGIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfd_pkg::pfd_mul_req_t req,
  output pfd_pkg::pfd_mul_rsp_t rsp
);
  import pfd_pkg::*;

  localparam int NDIG   = MUL_B_W / DIGIT_W;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int PART_W = MUL_A_W + DIGIT_W;

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_A_W-1:0] acc_r;
  logic [MUL_B_W-1:0] b_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [PART_W-1:0]  part;
  logic [PART_W-1:0]  sum;

  // one multiplier digit per cycle, lsb first
  assign part = {{DIGIT_W{1'b0}}, a_r} * {{MUL_A_W{1'b0}}, b_r[DIGIT_W-1:0]};
  assign sum  = {{DIGIT_W{1'b0}}, acc_r} + part;

  // digit counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NDIG);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // high part accumulates, low product digits shift in behind the multiplier
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= sum[PART_W-1:DIGIT_W];
      b_r   <= {sum[DIGIT_W-1:0], b_r[MUL_B_W-1:DIGIT_W]};
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = {acc_r, b_r};

endmodule

FILE: sv/pfd_serial_div.sv
module pfd_serial_div #(
  parameter int STEP_W = pfd_pkg::DIV_STEP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfd_pkg::pfd_div_req_t req,
  output pfd_pkg::pfd_div_rsp_t rsp
);
  import pfd_pkg::*;

  localparam int NSTEP = DIV_NUM_W / STEP_W;
  localparam int CNT_W = $clog2(NSTEP + 1);

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W-1:0] rem_c;
  logic [DIV_NUM_W-1:0] num_c;

  // restoring steps: dividend bits leave at the top, quotient bits enter below
  always_comb begin
    rem_c = rem_r;
    num_c = num_r;
    trial = '0;
    for (int i = 0; i < STEP_W; i++) begin
      trial = {rem_c, num_c[DIV_NUM_W-1]};
      num_c = {num_c[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial    = trial - {1'b0, den_r};
        num_c[0] = 1'b1;
      end
      rem_c = trial[DIV_DEN_W-1:0];
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NSTEP);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend / quotient and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      num_r <= num_c;
      rem_r <= rem_c;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

FILE: sv/pid_filtered_derivative_top.sv
// PID controller with a low-pass filtered derivative and a clamped integral, Q16.16.
// An update item (command 0) carries an error and a time step; the block forms the
// derivative as the error difference over the step (zero for a zero step, saturated),
// adds integ_gain*error*step to the integral and clamps it to +/- integ_limit, filters
// the derivative with weight deriv_alpha (values above one act as one) and returns
// the saturated drive prop_gain*e + integral + deriv_gain*filtered derivative, plus
// the integral. A clear item (command 1) zeroes integral, filtered derivative and
// previous error and returns the last drive with a zero integral. Items are worked
// one at a time. An update is paced by the one shared digit-serial multiplier that
// forms five products in turn; the divider runs beside the first three products.
// The next item is taken as soon as the result sits in the output register.
// Registers are written through the cfg port while no item is in flight: this binds
// the user, and the block itself does not enforce it.
module pid_filtered_derivative_top #(
  parameter int MUL_DIGIT = pfd_pkg::MUL_DIGIT_DEF,
  parameter int DIV_STEP  = pfd_pkg::DIV_STEP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic signed [pfd_pkg::DATA_W-1:0]  in_error_in,
  input  logic        [pfd_pkg::DT_W-1:0]    in_time_step,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pfd_pkg::DATA_W-1:0]  out_drive,
  output logic signed [pfd_pkg::DATA_W-1:0]  out_integ_term,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [pfd_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [pfd_pkg::DATA_W-1:0]  cfg_wdata
);
  import pfd_pkg::*;

  function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
    mag_of = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

  pfd_state_t state_r, state_nxt;

  // configuration
  logic signed [DATA_W-1:0] kp_r, kd_r, ki_r;
  logic [LIM_W-1:0]         lim_r;
  logic [ALPHA_W-1:0]       alpha_r;

  // loop state
  logic signed [DATA_W-1:0] prev_r, integ_r, filt_r, held_r;

  // item and scratch
  logic signed [DATA_W-1:0]         e_r;
  logic [DT_W-1:0]                  dt_r;
  logic                             neg_r;
  logic                             raw_neg_r;
  logic signed [DATA_W-1:0]         raw_r;
  logic signed [SUM_W-1:0]          sum_r;
  logic signed [KPROD_W-FRAC_W-1:0] kpe_r;
  logic                             div_done_r;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_drive_r, out_integ_r;

  pfd_mul_req_t mul_req;
  pfd_mul_rsp_t mul_rsp;
  pfd_div_req_t div_req;
  pfd_div_rsp_t div_rsp;
  logic         mul_neg;
  logic         out_load;
  logic         div_fin;

  logic signed [DATA_W:0]           diff, diff_neg;
  logic [DATA_W-1:0]                diff_mag;
  logic signed [SUM_W-1:0]          inc_mag, sum_calc, lim_s;
  logic signed [DATA_W-1:0]         clamp_val;
  logic signed [KPROD_W-1:0]        prod_pos, prod_s;
  logic signed [KPROD_W-FRAC_W-1:0] prod_top;
  logic [DIV_NUM_W-1:0]             q;
  logic signed [DATA_W-1:0]         raw_calc;
  logic signed [DATA_W:0]           fd, fd_neg;
  logic [DATA_W:0]                  fd_mag;
  logic [ALPHA_W-1:0]               alpha_eff;
  logic signed [FILT_P_W:0]         fp_pos, fp_s;
  logic signed [FILT_P_W-FRAC_W:0]  f_inc;
  logic signed [DATA_W-1:0]         filt_nxt;
  logic signed [DRV_W-1:0]          y;
  logic signed [DATA_W-1:0]         drive_sat;

  pfd_serial_mul #(.DIGIT_W(MUL_DIGIT)) u_pfd_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pfd_serial_div #(.STEP_W(DIV_STEP)) u_pfd_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // error difference for the derivative
  assign diff     = $signed({e_r[DATA_W-1], e_r}) - $signed({prev_r[DATA_W-1], prev_r});
  assign diff_neg = -diff;
  assign diff_mag = diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];

  // integral sum and clamp
  assign inc_mag  = $signed(SUM_W'(mul_rsp.product[DATA_W+INC_W-1:DATA_W]));
  assign sum_calc = SUM_W'(integ_r) + (neg_r ? -inc_mag : inc_mag);
  assign lim_s    = $signed(SUM_W'(lim_r));

  always_comb begin
    if (sum_r > lim_s) begin
      clamp_val = $signed({1'b0, lim_r});
    end else if (sum_r < -lim_s) begin
      clamp_val = -$signed({1'b0, lim_r});
    end else begin
      clamp_val = sum_r[DATA_W-1:0];
    end
  end

  // signed gain product, floored to Q16.16
  assign prod_pos = $signed({1'b0, mul_rsp.product[MUL_A_W-1:0]});
  assign prod_s   = neg_r ? -prod_pos : prod_pos;
  assign prod_top = prod_s[KPROD_W-1:FRAC_W];

  // raw derivative from the quotient, truncated toward zero and saturated
  assign q       = div_rsp.quot;
  assign div_fin = div_done_r || div_rsp.done;

  always_comb begin
    if (dt_r == '0) begin
      raw_calc = '0;
    end else if (raw_neg_r) begin
      if (q[DIV_NUM_W-1:DATA_W] != '0 || (q[DATA_W-1] && q[DATA_W-2:0] != '0)) begin
        raw_calc = DATA_MIN;
      end else begin
        raw_calc = -q[DATA_W-1:0];
      end
    end else begin
      raw_calc = (q[DIV_NUM_W-1:DATA_W-1] != '0) ? DATA_MAX : q[DATA_W-1:0];
    end
  end

  // filter: d + floor(alpha * (raw - d) / 2^16)
  assign fd        = $signed({raw_r[DATA_W-1], raw_r}) - $signed({filt_r[DATA_W-1], filt_r});
  assign fd_neg    = -fd;
  assign fd_mag    = fd[DATA_W] ? fd_neg : fd;
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign fp_pos    = $signed({1'b0, mul_rsp.product[FILT_P_W-1:0]});
  assign fp_s      = neg_r ? -fp_pos : fp_pos;
  assign f_inc     = fp_s[FILT_P_W:FRAC_W];
  assign filt_nxt  = filt_r + $signed(f_inc[DATA_W-1:0]);

  // drive sum and saturation
  assign y = DRV_W'(kpe_r) + DRV_W'(integ_r) + DRV_W'(prod_top);

  always_comb begin
    if (y[DRV_W-1:DATA_W-1] == '0 || y[DRV_W-1:DATA_W-1] == '1) begin
      drive_sat = y[DATA_W-1:0];
    end else begin
      drive_sat = y[DRV_W-1] ? DATA_MIN : DATA_MAX;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = in_command ? ST_CLEAR : ST_START;
      ST_START:  state_nxt = ST_GE;
      ST_GE:     if (mul_rsp.done) state_nxt = ST_GEDT;
      ST_GEDT:   if (mul_rsp.done) state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_KPE;
      ST_KPE:    if (mul_rsp.done) state_nxt = ST_WDIV;
      ST_WDIV:   if (div_fin) state_nxt = ST_FSTART;
      ST_FSTART: state_nxt = ST_FILT;
      ST_FILT:   if (mul_rsp.done) state_nxt = ST_KSTART;
      ST_KSTART: state_nxt = ST_KDF;
      ST_KDF:    if (mul_rsp.done) state_nxt = ST_DONE;
      ST_CLEAR:  state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // unit requests and handshake
  always_comb begin
    mul_req  = '0;
    div_req  = '0;
    mul_neg  = neg_r;
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_START: begin
        div_req.start = 1'b1;
        div_req.num   = {diff_mag, {FRAC_W{1'b0}}};
        div_req.den   = dt_r;
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(mag_of(ki_r));
        mul_req.b     = mag_of(e_r);
        mul_neg       = ki_r[DATA_W-1] ^ e_r[DATA_W-1];
      end
      ST_GE: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product[MUL_A_W-1:0];
          mul_req.b     = MUL_B_W'(dt_r);
        end
      end
      ST_CLAMP: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(mag_of(kp_r));
        mul_req.b     = mag_of(e_r);
        mul_neg       = kp_r[DATA_W-1] ^ e_r[DATA_W-1];
      end
      ST_FSTART: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(fd_mag);
        mul_req.b     = MUL_B_W'(alpha_eff);
        mul_neg       = fd[DATA_W];
      end
      ST_KSTART: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(mag_of(kd_r));
        mul_req.b     = mag_of(filt_r);
        mul_neg       = kd_r[DATA_W-1] ^ filt_r[DATA_W-1];
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // state, configuration, loop state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kp_r        <= PROP_GAIN_RST;
      kd_r        <= DERIV_GAIN_RST;
      ki_r        <= INTEG_GAIN_RST;
      lim_r       <= INTEG_LIMIT_RST;
      alpha_r     <= DERIV_ALPHA_RST;
      prev_r      <= '0;
      integ_r     <= '0;
      filt_r      <= '0;
      held_r      <= '0;
      div_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register write transfer
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PROP_GAIN:   kp_r    <= cfg_wdata;
          REG_DERIV_GAIN:  kd_r    <= cfg_wdata;
          REG_INTEG_GAIN:  ki_r    <= cfg_wdata;
          REG_INTEG_LIMIT: lim_r   <= cfg_wdata[LIM_W-1:0];
          REG_DERIV_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
          default: ;
        endcase
      end

      // loop state updates
      if (state_r == ST_START) prev_r <= e_r;
      if (state_r == ST_CLAMP) integ_r <= clamp_val;
      if (state_r == ST_FILT && mul_rsp.done) filt_r <= filt_nxt;
      if (state_r == ST_KDF && mul_rsp.done) held_r <= drive_sat;
      if (state_r == ST_CLEAR) begin
        prev_r  <= '0;
        integ_r <= '0;
        filt_r  <= '0;
      end

      // quotient ready flag
      if (div_req.start) begin
        div_done_r <= 1'b0;
      end else if (div_rsp.done) begin
        div_done_r <= 1'b1;
      end

      // result transfer
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and intermediate results
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      e_r  <= in_error_in;
      dt_r <= in_time_step;
    end
    if (mul_req.start) neg_r <= mul_neg;
    if (state_r == ST_START) raw_neg_r <= diff[DATA_W];
    if (state_r == ST_GEDT && mul_rsp.done) sum_r <= sum_calc;
    if (state_r == ST_KPE && mul_rsp.done) kpe_r <= prod_top;
    if (state_r == ST_WDIV && div_fin) raw_r <= raw_calc;
    if (out_load) begin
      out_drive_r <= held_r;
      out_integ_r <= integ_r;
    end
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_drive      = out_drive_r;
  assign out_integ_term = out_integ_r;

endmodule

FILE: sv/pfd_checker.sv
module pfd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [pfd_pkg::DATA_W-1:0]  out_drive,
  input logic signed [pfd_pkg::DATA_W-1:0]  out_integ_term,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic        [pfd_pkg::IDX_W-1:0]   cfg_index,
  input logic        [pfd_pkg::DATA_W-1:0]  cfg_wdata
);
  import pfd_pkg::*;

  logic [LIM_W-1:0]         lim_r;
  logic [1:0]               pend_r;
  logic                     in_acc, out_acc;
  logic signed [DATA_W-1:0] lim_pos, lim_neg;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign lim_pos = $signed({1'b0, lim_r});
  assign lim_neg = -lim_pos;

  // shadow of the integral limit and count of items not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r  <= INTEG_LIMIT_RST;
      pend_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == REG_INTEG_LIMIT) begin
        lim_r <= cfg_wdata[LIM_W-1:0];
      end
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_integ_term))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while an item is in work");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an outstanding item");

  // at most one result waiting when a new item comes in
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("too many items outstanding");

  // reported integral lies within the clamp
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_integ_term <= lim_pos && out_integ_term >= lim_neg)
    else $error("integral outside the clamp");

endmodule

bind pid_filtered_derivative_top pfd_checker u_pfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_drive      (out_drive),
  .out_integ_term (out_integ_term),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_index      (cfg_index),
  .cfg_wdata      (cfg_wdata)
);

FILE: bench/pfd_loop_checker.sv
// watches the item, result and register channels of the pid block, predicts each
// result from its own copy of the loop state and compares in order of arrival
module pfd_loop_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_command,
  input  logic signed [pfd_pkg::DATA_W-1:0] in_error_in,
  input  logic        [pfd_pkg::DT_W-1:0]   in_time_step,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [pfd_pkg::DATA_W-1:0] out_drive,
  input  logic signed [pfd_pkg::DATA_W-1:0] out_integ_term,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic        [pfd_pkg::IDX_W-1:0]  cfg_index,
  input  logic        [pfd_pkg::DATA_W-1:0] cfg_wdata,
  output int                                mismatch_count,
  output int                                results_checked,
  output int                                results_due
);

  localparam longint Q_ONE   = longint'(1) << pfd_pkg::FRAC_W;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam int     REPORT_MAX = 10;

  typedef struct {
    logic signed [pfd_pkg::DATA_W-1:0] drive;
    logic signed [pfd_pkg::DATA_W-1:0] integ;
  } drive_result_t;

  // register copy
  logic signed [pfd_pkg::DATA_W-1:0] kp, kd, ki;
  logic        [pfd_pkg::LIM_W-1:0]   integ_lim;
  logic        [pfd_pkg::ALPHA_W-1:0] alpha;

  // loop state copy
  logic signed [pfd_pkg::DATA_W-1:0] prev_err, integ_acc, deriv_filt, held_out;

  drive_result_t drive_due[$];
  int            failures;

  function automatic longint clip32(input longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // one loop update or clear, returns the result it produces
  function automatic drive_result_t advance_loop(input logic cmd,
                                                 input logic signed [31:0] err,
                                                 input logic [23:0] dt);
    drive_result_t     r;
    longint            slope, prod, inc, acc, lim, weight, mix, sum;
    longint unsigned   mag, part;
    if (cmd) begin
      integ_acc  = '0;
      deriv_filt = '0;
      prev_err   = '0;
      r.drive    = held_out;
      r.integ    = '0;
      return r;
    end

    // raw derivative, zero for a zero step
    slope = 0;
    if (dt != '0)
      slope = clip32(((longint'(err) - longint'(prev_err)) * Q_ONE) / longint'(dt));
    prev_err = err;

    // integral increment: exact triple product, truncated toward zero
    prod = longint'(ki) * longint'(err);
    mag  = (prod < 0) ? longint'(-prod) : longint'(prod);
    part = (mag >> 32) * longint'(dt) + (((mag & 64'hFFFF_FFFF) * longint'(dt)) >> 32);
    inc  = (prod < 0) ? -longint'(part) : longint'(part);
    acc  = longint'(integ_acc) + inc;
    lim  = longint'(integ_lim);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ_acc = acc[31:0];

    // low-pass filter, weights above one act as one
    weight = (longint'(alpha) > Q_ONE) ? Q_ONE : longint'(alpha);
    mix = (Q_ONE - weight) * longint'(deriv_filt) + weight * slope;
    deriv_filt = 32'(mix >>> pfd_pkg::FRAC_W);

    // saturated drive
    sum = ((longint'(kp) * longint'(err)) >>> pfd_pkg::FRAC_W) + longint'(integ_acc) +
          ((longint'(kd) * longint'(deriv_filt)) >>> pfd_pkg::FRAC_W);
    held_out = 32'(clip32(sum));

    r.drive = held_out;
    r.integ = integ_acc;
    return r;
  endfunction

  function automatic void apply_reg(input logic [pfd_pkg::IDX_W-1:0] idx,
                                    input logic [pfd_pkg::DATA_W-1:0] val);
    case (pfd_pkg::pfd_reg_t'(idx))
      pfd_pkg::REG_PROP_GAIN:   kp = val;
      pfd_pkg::REG_DERIV_GAIN:  kd = val;
      pfd_pkg::REG_INTEG_GAIN:  ki = val;
      pfd_pkg::REG_INTEG_LIMIT: integ_lim = val[pfd_pkg::LIM_W-1:0];
      pfd_pkg::REG_DERIV_ALPHA: alpha = val[pfd_pkg::ALPHA_W-1:0];
      default: ;
    endcase
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin : track
    drive_result_t want;
    if (!rst_n) begin
      kp         = pfd_pkg::PROP_GAIN_RST;
      kd         = pfd_pkg::DERIV_GAIN_RST;
      ki         = pfd_pkg::INTEG_GAIN_RST;
      integ_lim  = pfd_pkg::INTEG_LIMIT_RST;
      alpha      = pfd_pkg::DERIV_ALPHA_RST;
      prev_err   = '0;
      integ_acc  = '0;
      deriv_filt = '0;
      held_out   = '0;
      failures   = 0;
      drive_due.delete();
      mismatch_count  <= 0;
      results_checked <= 0;
      results_due     <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        drive_due.push_back(advance_loop(in_command, in_error_in, in_time_step));
      // result transfer
      if (out_valid && !out_stall) begin
        if (drive_due.size() == 0) begin
          if (failures < REPORT_MAX)
            $display("unexpected result: drive %0d integ %0d", out_drive, out_integ_term);
          failures++;
        end else begin
          want = drive_due.pop_front();
          if (out_drive !== want.drive || out_integ_term !== want.integ) begin
            if (failures < REPORT_MAX)
              $display("mismatch on result %0d: drive exp %0d got %0d, integ exp %0d got %0d",
                       results_checked, want.drive, out_drive, want.integ, out_integ_term);
            failures++;
          end
          results_checked <= results_checked + 1;
        end
      end
      mismatch_count <= failures;
      results_due    <= drive_due.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 65;
  localparam int TRAJ_SPAN   = 1 << 22;
  localparam logic [pfd_pkg::DT_W-1:0]   DT_MAX    = '1;
  localparam logic [pfd_pkg::IDX_W-1:0]  LAST_REG  = pfd_pkg::REG_DERIV_ALPHA;
  localparam logic [pfd_pkg::ALPHA_W-1:0] ALPHA_TOP = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic signed [pfd_pkg::DATA_W-1:0] in_error_in = '0;
  logic        [pfd_pkg::DT_W-1:0]   in_time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pfd_pkg::DATA_W-1:0] out_drive, out_integ_term;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pfd_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [pfd_pkg::DATA_W-1:0] cfg_wdata = '0;

  int mismatches, checked, pending;
  int cycle_count = 0;
  int updates = 0, clears = 0, settings = 0;
  int stall_left = 0;
  int traj_err = 0;
  logic quiet_in = 1'b0, quiet_out = 1'b0;

  always #5 clk = ~clk;

  pid_filtered_derivative_top dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_error_in, .in_time_step,
    .out_valid, .out_stall, .out_drive, .out_integ_term,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  pfd_loop_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_command, .in_error_in, .in_time_step,
    .out_valid, .out_stall, .out_drive, .out_integ_term,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .mismatch_count(mismatches), .results_checked(checked), .results_due(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result-side back-pressure: mostly short runs, now and then a long stall
  always @(posedge clk) begin : backpressure
    int roll;
    if (!rst_n || quiet_out) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else if (roll < 90) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else if (roll < 97) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(4, 20);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(40, 120);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (quiet_in) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // one item transfer, entered and left at a rising edge
  task automatic send_item(input logic cmd, input logic signed [31:0] err,
                           input logic [pfd_pkg::DT_W-1:0] dt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_error_in  <= err;
    in_time_step <= dt;
    do @(posedge clk); while (in_stall);
    if (cmd) clears++;
    else updates++;
  endtask

  task automatic write_reg(input logic [pfd_pkg::IDX_W-1:0] idx,
                           input logic [pfd_pkg::DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_loop(input logic [31:0] kp, input logic [31:0] kd,
                              input logic [31:0] ki, input logic [31:0] lim,
                              input logic [31:0] alpha);
    write_reg(pfd_pkg::REG_PROP_GAIN, kp);
    write_reg(pfd_pkg::REG_DERIV_GAIN, kd);
    write_reg(pfd_pkg::REG_INTEG_GAIN, ki);
    write_reg(pfd_pkg::REG_INTEG_LIMIT, lim);
    write_reg(pfd_pkg::REG_DERIV_ALPHA, alpha);
    // index past the last register, must be ignored
    if ($urandom_range(0, 2) == 0)
      write_reg(LAST_REG + 3'd1 + 3'($urandom_range(0, 2)), $urandom);
    settings++;
  endtask

  function automatic logic [31:0] pick_gain(input int style);
    case (style)
      0: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return pfd_pkg::DATA_MAX;
          1: return pfd_pkg::DATA_MIN;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_limit(input int style);
    case (style)
      0: return $urandom_range(0, 1 << 22);
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'd1;
          2: return pfd_pkg::DATA_MAX;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'(pfd_pkg::ALPHA_ONE);
      2: return 32'(ALPHA_TOP);
      3: return $urandom;
      default: return $urandom_range(0, 32'(pfd_pkg::ALPHA_ONE));
    endcase
  endfunction

  // smooth error trajectories for most items, raw noise and clears for the rest
  task automatic random_item(input int base_dt);
    int                            roll;
    logic signed [31:0]            err;
    logic [pfd_pkg::DT_W-1:0]      dt;
    roll = $urandom_range(0, 99);
    if (roll < 7) begin
      send_item(1'b1, $urandom, 24'($urandom));
    end else if (roll < 77) begin
      traj_err = traj_err + int'($urandom_range(0, 1 << 16)) - (1 << 15);
      if (traj_err > TRAJ_SPAN || traj_err < -TRAJ_SPAN) traj_err = traj_err / 2;
      dt = 24'(base_dt + $urandom_range(0, base_dt / 8));
      if ($urandom_range(0, 29) == 0) dt = '0;
      send_item(1'b0, traj_err, dt);
    end else begin
      case ($urandom_range(0, 4))
        0: err = pfd_pkg::DATA_MAX;
        1: err = pfd_pkg::DATA_MIN;
        2: err = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        default: err = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: dt = '0;
        1: dt = 24'd1;
        2: dt = DT_MAX;
        3: dt = 24'($urandom_range(1, 1 << 12));
        default: dt = 24'($urandom);
      endcase
      send_item(1'b0, err, dt);
    end
  endtask

  initial begin
    int style, base_dt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: held drive after reset, zero step, step and error extremes
    send_item(1'b1, $urandom, 24'($urandom));
    send_item(1'b0, '0, '0);
    send_item(1'b0, 32'sd65536, 24'd65536);
    send_item(1'b0, pfd_pkg::DATA_MAX, DT_MAX);
    send_item(1'b0, pfd_pkg::DATA_MIN, 24'd1);
    send_item(1'b0, pfd_pkg::DATA_MAX, 24'd1);
    send_item(1'b0, -32'sd1, '0);
    send_item(1'b1, $urandom, DT_MAX);
    send_item(1'b0, pfd_pkg::DATA_MIN, DT_MAX);
    send_item(1'b0, '0, 24'd1);
    drain();

    // largest gains, widest clamp, filter weight above one
    program_loop(pfd_pkg::DATA_MAX, pfd_pkg::DATA_MAX, pfd_pkg::DATA_MAX,
                 pfd_pkg::DATA_MAX, 32'(ALPHA_TOP));
    send_item(1'b0, pfd_pkg::DATA_MAX, DT_MAX);
    send_item(1'b0, pfd_pkg::DATA_MIN, DT_MAX);
    send_item(1'b0, pfd_pkg::DATA_MIN, 24'd1);
    send_item(1'b1, '0, '0);
    send_item(1'b0, pfd_pkg::DATA_MAX, 24'd1);
    send_item(1'b0, 32'sd1, 24'd1);
    drain();

    // most negative gains, zero clamp, zero filter weight
    program_loop(pfd_pkg::DATA_MIN, pfd_pkg::DATA_MIN, pfd_pkg::DATA_MIN, '0, '0);
    send_item(1'b0, pfd_pkg::DATA_MIN, DT_MAX);
    send_item(1'b0, pfd_pkg::DATA_MAX, 24'd1);
    send_item(1'b0, '0, '0);
    send_item(1'b1, '1, DT_MAX);
    send_item(1'b0, pfd_pkg::DATA_MIN, 24'd1);
    drain();

    // random phases, each under its own register setting and idling mix
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      style = $urandom_range(0, 3);
      if (style == 3) style = 0;
      program_loop(pick_gain(style), pick_gain(style), pick_gain(style),
                   pick_limit(style), pick_alpha());
      quiet_in  = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      base_dt   = $urandom_range(1, 1 << 16);
      traj_err  = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(base_dt);
        if ($urandom_range(0, 39) == 0) quiet_in = ~quiet_in;
      end
      drain();
      quiet_in  = 1'b0;
      quiet_out = 1'b0;
    end

    // room for any stray result
    repeat (80) @(posedge clk);

    $display("covered %0d updates and %0d clears under %0d register settings",
             updates, clears, settings + 1);
    $display("%0d results compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
